FILE: hdl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants, request codes, controller states and the command/status
// bundles between the window tracker controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

  localparam int DEF_WINDOW_DEPTH = 512;
  localparam int DEF_SAMPLE_BITS  = 32;
  localparam int LEN_BITS         = 10;

  localparam logic [LEN_BITS-1:0] WINDOW_RESET = 10'd500;

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_EV_RD,
    S_EV_CHK,
    S_WRITE,
    S_SCAN_INIT,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic ev_rd;
    logic ev_chk;
    logic wr;
    logic scan_init;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic ge_eff;
    logic gt_eff;
    logic rescan;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/swmm_if.sv
// ----------------------------------------------------------------------------
// swmm channel interfaces
// Request, result and window length write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface swmm_in_if
  import swmm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [SAMPLE_BITS-1:0] x_sample;
  logic signed [SAMPLE_BITS-1:0] y_sample;

  modport source (output valid, req_type, x_sample, y_sample, input ready);
  modport sink (input valid, req_type, x_sample, y_sample, output ready);
endinterface

interface swmm_out_if
  import swmm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] min_x;
  logic signed [SAMPLE_BITS-1:0] max_x;
  logic signed [SAMPLE_BITS-1:0] min_y;
  logic signed [SAMPLE_BITS-1:0] max_y;
  logic        [LEN_BITS-1:0]    fill_count;

  modport source (output valid, min_x, max_x, min_y, max_y, fill_count, input ready);
  modport sink (input valid, min_x, max_x, min_y, max_y, fill_count, output ready);
endinterface

interface swmm_cfg_if
  import swmm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LEN_BITS-1:0] window_len;

  modport source (output valid, window_len, input ready);
  modport sink (input valid, window_len, output ready);
endinterface

`default_nettype wire

FILE: hdl/swmm_ctrl.sv
// ----------------------------------------------------------------------------
// swmm_ctrl
// Sequencer: accepts a request; for an add it runs evictions, the write and
// an optional window rescan, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_ctrl
  import swmm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.is_clear) begin
          state_nxt = S_DONE;
        end else if (sts.ge_eff) begin
          state_nxt = S_EV_RD;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_EV_RD: begin
        cmd.ev_rd = 1'b1;
        state_nxt = S_EV_CHK;
      end
      S_EV_CHK: begin
        cmd.ev_chk = 1'b1;
        // held count drops by one this cycle
        state_nxt  = sts.gt_eff ? S_EV_RD : S_WRITE;
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = sts.rescan ? S_SCAN_INIT : S_DONE;
      end
      S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/swmm_dp.sv
// ----------------------------------------------------------------------------
// swmm_dp
// Window datapath: two ring buffer memories, pointer and count, the four
// extremes, the window length register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_dp
  import swmm_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
)(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [LEN_BITS-1:0]           cfg_len,
  input  wire logic                          in_req_type,
  input  wire logic signed [SAMPLE_BITS-1:0] in_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_y,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      out_min_x,
  output logic signed [SAMPLE_BITS-1:0]      out_max_x,
  output logic signed [SAMPLE_BITS-1:0]      out_min_y,
  output logic signed [SAMPLE_BITS-1:0]      out_max_y,
  output logic [LEN_BITS-1:0]                out_fill,
  input  wire cmd_t                          cmd,
  output sts_t                               sts
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int EFF_W = (CNT_W > LEN_BITS) ? CNT_W : LEN_BITS;
  localparam int SUM_W = CNT_W + 1;

  localparam logic [EFF_W-1:0] DEPTH_EFF = EFF_W'(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(WINDOW_DEPTH);
  localparam logic [PTR_W:0]   DEPTH_PTR = (PTR_W + 1)'(WINDOW_DEPTH);

  logic signed [SAMPLE_BITS-1:0] mem_x [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] mem_y [WINDOW_DEPTH];

  logic [LEN_BITS-1:0]           win_len_r,  win_len_nxt;
  logic [CNT_W-1:0]              held_r,     held_nxt;
  logic [PTR_W-1:0]              oldest_r,   oldest_nxt;
  logic signed [SAMPLE_BITS-1:0] lo_x_r,     lo_x_nxt;
  logic signed [SAMPLE_BITS-1:0] hi_x_r,     hi_x_nxt;
  logic signed [SAMPLE_BITS-1:0] lo_y_r,     lo_y_nxt;
  logic signed [SAMPLE_BITS-1:0] hi_y_r,     hi_y_nxt;
  logic                          req_r,      req_nxt;
  logic signed [SAMPLE_BITS-1:0] xs_r,       xs_nxt;
  logic signed [SAMPLE_BITS-1:0] ys_r,       ys_nxt;
  logic                          flag_r,     flag_nxt;
  logic [PTR_W-1:0]              scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]              scan_left_r, scan_left_nxt;
  logic                          scan_vld_r, scan_vld_nxt;
  logic                          scan_first_r, scan_first_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] rd_x_r;
  logic signed [SAMPLE_BITS-1:0] rd_y_r;
  logic signed [SAMPLE_BITS-1:0] o_min_x_r, o_max_x_r, o_min_y_r, o_max_y_r;
  logic [LEN_BITS-1:0]           o_fill_r;

  logic [EFF_W-1:0] len_ext;
  logic [EFF_W-1:0] held_ext;
  logic [EFF_W-1:0] eff;
  logic [PTR_W:0]   oldest_inc;
  logic [PTR_W-1:0] oldest_next;
  logic [PTR_W:0]   scan_inc;
  logic [PTR_W-1:0] scan_next;
  logic [SUM_W-1:0] wr_sum;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  logic             scan_issue;

  // effective window length: zero means one, saturate at the depth
  always_comb begin
    len_ext  = EFF_W'(win_len_r);
    held_ext = EFF_W'(held_r);
    if (len_ext == '0) begin
      eff = EFF_W'(1);
    end else if (len_ext > DEPTH_EFF) begin
      eff = DEPTH_EFF;
    end else begin
      eff = len_ext;
    end
  end

  // ring pointer steps and the write slot after the newest entry
  always_comb begin
    oldest_inc  = (PTR_W + 1)'(oldest_r) + (PTR_W + 1)'(1);
    oldest_next = (oldest_inc >= DEPTH_PTR) ? '0 : oldest_inc[PTR_W-1:0];
    scan_inc    = (PTR_W + 1)'(scan_ptr_r) + (PTR_W + 1)'(1);
    scan_next   = (scan_inc >= DEPTH_PTR) ? '0 : scan_inc[PTR_W-1:0];
    wr_sum      = SUM_W'(oldest_r) + SUM_W'(held_r);
    wr_addr     = (wr_sum >= DEPTH_SUM) ? PTR_W'(wr_sum - DEPTH_SUM) : PTR_W'(wr_sum);
    rd_addr     = cmd.ev_rd ? oldest_r : scan_ptr_r;
    scan_issue  = cmd.scan_step && (scan_left_r != '0);
  end

  always_comb begin
    win_len_nxt    = win_len_r;
    held_nxt       = held_r;
    oldest_nxt     = oldest_r;
    lo_x_nxt       = lo_x_r;
    hi_x_nxt       = hi_x_r;
    lo_y_nxt       = lo_y_r;
    hi_y_nxt       = hi_y_r;
    req_nxt        = req_r;
    xs_nxt         = xs_r;
    ys_nxt         = ys_r;
    flag_nxt       = flag_r;
    scan_ptr_nxt   = scan_ptr_r;
    scan_left_nxt  = scan_left_r;
    scan_vld_nxt   = scan_issue;
    scan_first_nxt = scan_first_r;
    out_valid_nxt  = out_valid_r;

    if (cfg_valid) begin
      win_len_nxt = cfg_len;
    end

    if (cmd.take) begin
      req_nxt  = in_req_type;
      xs_nxt   = in_x;
      ys_nxt   = in_y;
      flag_nxt = 1'b0;
      if (in_req_type == REQ_CLEAR) begin
        held_nxt   = '0;
        oldest_nxt = '0;
        lo_x_nxt   = '0;
        hi_x_nxt   = '0;
        lo_y_nxt   = '0;
        hi_y_nxt   = '0;
      end else if (held_r == '0) begin
        lo_x_nxt = in_x;
        hi_x_nxt = in_x;
        lo_y_nxt = in_y;
        hi_y_nxt = in_y;
      end else begin
        if (in_x < lo_x_r) lo_x_nxt = in_x;
        if (in_x > hi_x_r) hi_x_nxt = in_x;
        if (in_y < lo_y_r) lo_y_nxt = in_y;
        if (in_y > hi_y_r) hi_y_nxt = in_y;
      end
    end

    // evicted value on an extreme marks the window for a rescan
    if (cmd.ev_chk) begin
      if (rd_x_r >= hi_x_r || rd_x_r <= lo_x_r ||
          rd_y_r >= hi_y_r || rd_y_r <= lo_y_r) begin
        flag_nxt = 1'b1;
      end
      oldest_nxt = oldest_next;
      held_nxt   = held_r - CNT_W'(1);
    end

    if (cmd.wr) begin
      held_nxt = held_r + CNT_W'(1);
    end

    if (cmd.scan_init) begin
      scan_ptr_nxt   = oldest_r;
      scan_left_nxt  = held_r;
      scan_first_nxt = 1'b1;
    end

    if (scan_issue) begin
      scan_ptr_nxt  = scan_next;
      scan_left_nxt = scan_left_r - CNT_W'(1);
    end

    // read data is registered and arrives in the cycle after its address
    if (scan_vld_r) begin
      scan_first_nxt = 1'b0;
      if (scan_first_r) begin
        lo_x_nxt = rd_x_r;
        hi_x_nxt = rd_x_r;
        lo_y_nxt = rd_y_r;
        hi_y_nxt = rd_y_r;
      end else begin
        if (rd_x_r < lo_x_r) lo_x_nxt = rd_x_r;
        if (rd_x_r > hi_x_r) hi_x_nxt = rd_x_r;
        if (rd_y_r < lo_y_r) lo_y_nxt = rd_y_r;
        if (rd_y_r > hi_y_r) hi_y_nxt = rd_y_r;
      end
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r    <= WINDOW_RESET;
      held_r       <= '0;
      oldest_r     <= '0;
      lo_x_r       <= '0;
      hi_x_r       <= '0;
      lo_y_r       <= '0;
      hi_y_r       <= '0;
      flag_r       <= 1'b0;
      scan_left_r  <= '0;
      scan_vld_r   <= 1'b0;
      scan_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      win_len_r    <= win_len_nxt;
      held_r       <= held_nxt;
      oldest_r     <= oldest_nxt;
      lo_x_r       <= lo_x_nxt;
      hi_x_r       <= hi_x_nxt;
      lo_y_r       <= lo_y_nxt;
      hi_y_r       <= hi_y_nxt;
      flag_r       <= flag_nxt;
      scan_left_r  <= scan_left_nxt;
      scan_vld_r   <= scan_vld_nxt;
      scan_first_r <= scan_first_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    xs_r       <= xs_nxt;
    ys_r       <= ys_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    if (cmd.load_out) begin
      o_min_x_r <= lo_x_r;
      o_max_x_r <= hi_x_r;
      o_min_y_r <= lo_y_r;
      o_max_y_r <= hi_y_r;
      o_fill_r  <= LEN_BITS'(held_r);
    end
  end

  // ring buffers: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_x[wr_addr] <= xs_r;
      mem_y[wr_addr] <= ys_r;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  always_comb begin
    sts.is_clear  = (req_r == REQ_CLEAR);
    sts.ge_eff    = (held_ext >= eff);
    sts.gt_eff    = (held_ext > eff);
    sts.rescan    = flag_r;
    sts.scan_done = (scan_left_r == '0) && !scan_vld_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_min_x = o_min_x_r;
  assign out_max_x = o_max_x_r;
  assign out_min_y = o_min_y_r;
  assign out_max_y = o_max_y_r;
  assign out_fill  = o_fill_r;

endmodule

`default_nettype wire

FILE: hdl/sliding_window_minmax_tracker.sv
// ----------------------------------------------------------------------------
// sliding_window_minmax_tracker
// Running min/max of x and y over the most recent window_len sample pairs.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_req    in   valid/ready    req_type, x_sample, y_sample
//  out_res   out  valid/ready    min_x, max_x, min_y, max_y, fill_count
//  cfg_wr    in   valid/ready    window_len (always ready)
//
//  one request at a time: a clear steps through idle, eval and done, an add with
//  no eviction through idle, eval, write and done; each evicted pair adds a read
//  and a compare step, and an eviction on an extreme adds a rescan of the held
//  window (scan init, then a read per held pair) after the write, before done.
//  synchronous active-low reset empties the window, window_len returns to 500.
//  a result waiting on out_res holds the controller in its done step.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_minmax_tracker
  import swmm_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
)(
  input  wire logic  clk,
  input  wire logic  rst_n,
  swmm_in_if.sink    in_req,
  swmm_out_if.source out_res,
  swmm_cfg_if.sink   cfg_wr
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_req.ready = in_ready;
  assign cfg_wr.ready = 1'b1;

  swmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swmm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_wr.valid),
    .cfg_len     (cfg_wr.window_len),
    .in_req_type (in_req.req_type),
    .in_x        (in_req.x_sample),
    .in_y        (in_req.y_sample),
    .out_ready   (out_res.ready),
    .out_valid   (out_res.valid),
    .out_min_x   (out_res.min_x),
    .out_max_x   (out_res.max_x),
    .out_min_y   (out_res.min_y),
    .out_max_y   (out_res.max_y),
    .out_fill    (out_res.fill_count),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

FILE: tb/tb_sliding_window_minmax_tracker.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_minmax_tracker
// Self-checking bench for the sliding window min/max tracker. A cycle-free
// model of the two ring buffers and the four extremes predicts every result.
// The bench covers corner samples, a full ring with mass eviction and random
// window lengths, with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_sliding_window_minmax_tracker;
  import swmm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH = DEF_WINDOW_DEPTH;
  localparam int SAMPLE_W  = DEF_SAMPLE_BITS;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PEND_DEPTH = 1024;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_x;
    logic signed [SAMPLE_W-1:0] max_x;
    logic signed [SAMPLE_W-1:0] min_y;
    logic signed [SAMPLE_W-1:0] max_y;
    logic [LEN_BITS-1:0]        fill;
  } window_summary_t;

  logic clk = 1'b0;
  logic rst_n;

  swmm_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_req ();
  swmm_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_res ();
  swmm_cfg_if                           cfg_wr ();

  sliding_window_minmax_tracker #(
    .WINDOW_DEPTH(WIN_DEPTH),
    .SAMPLE_BITS (SAMPLE_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  // shadow of the tracker state
  logic signed [SAMPLE_W-1:0] ring_x [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] ring_y [WIN_DEPTH];
  int unsigned                ring_head = 0;
  int unsigned                ring_fill = 0;
  logic signed [SAMPLE_W-1:0] lo_x = '0, hi_x = '0, lo_y = '0, hi_y = '0;
  logic [LEN_BITS-1:0]        window_len_reg = WINDOW_RESET;

  // expected results in request order
  window_summary_t pending_extremes [PEND_DEPTH];
  int unsigned     pend_wr = 0;
  int unsigned     pend_rd = 0;

  int  fail_count    = 0;
  int  checked_count = 0;
  int  request_count = 0;
  int  clear_count   = 0;
  int  len_writes    = 0;
  int  burst_left    = 0;
  logic [SAMPLE_W-1:0] ramp_val = '0;
  bit  holding = 1'b0;
  event hold_off_ev;

  // ---------------------------------------------------------------- predictor

  function automatic void scan_held(input bit use_y,
                                    output logic signed [SAMPLE_W-1:0] mn,
                                    output logic signed [SAMPLE_W-1:0] mx);
    int unsigned p;
    logic signed [SAMPLE_W-1:0] v;
    p  = ring_head;
    mn = use_y ? ring_y[p] : ring_x[p];
    mx = mn;
    for (int unsigned i = 0; i < ring_fill; i++) begin
      v = use_y ? ring_y[p] : ring_x[p];
      if (v < mn) mn = v;
      if (v > mx) mx = v;
      p = (p + 1) % WIN_DEPTH;
    end
  endfunction

  // a dropped pair at or beyond an extreme forces that extreme to be rebuilt
  function automatic void refresh_after_drop(input logic signed [SAMPLE_W-1:0] ox,
                                             input logic signed [SAMPLE_W-1:0] oy);
    logic signed [SAMPLE_W-1:0] mn, mx;
    scan_held(1'b0, mn, mx);
    if (ox >= hi_x) hi_x = mx;
    if (ox <= lo_x) lo_x = mn;
    scan_held(1'b1, mn, mx);
    if (oy >= hi_y) hi_y = mx;
    if (oy <= lo_y) lo_y = mn;
  endfunction

  function automatic window_summary_t apply_request(input logic kind,
                                                    input logic signed [SAMPLE_W-1:0] xs,
                                                    input logic signed [SAMPLE_W-1:0] ys);
    int unsigned eff;
    int unsigned wr;
    logic signed [SAMPLE_W-1:0] ox, oy;
    window_summary_t s;
    if (kind == REQ_CLEAR) begin
      ring_fill = 0;
      ring_head = 0;
      lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
    end else begin
      eff = window_len_reg;
      if (eff == 0) eff = 1;
      if (eff > WIN_DEPTH) eff = WIN_DEPTH;
      if (ring_fill == 0) begin
        lo_x = xs; hi_x = xs; lo_y = ys; hi_y = ys;
      end else begin
        if (xs > hi_x) hi_x = xs;
        if (ys > hi_y) hi_y = ys;
        if (xs < lo_x) lo_x = xs;
        if (ys < lo_y) lo_y = ys;
      end
      if (ring_fill >= WIN_DEPTH) begin
        // full ring: the new pair overwrites the oldest
        ox = ring_x[ring_head];
        oy = ring_y[ring_head];
        ring_x[ring_head] = xs;
        ring_y[ring_head] = ys;
        ring_head = (ring_head + 1) % WIN_DEPTH;
        refresh_after_drop(ox, oy);
      end else begin
        wr = (ring_head + ring_fill) % WIN_DEPTH;
        ring_x[wr] = xs;
        ring_y[wr] = ys;
        ring_fill++;
      end
      while (ring_fill > eff) begin
        ox = ring_x[ring_head];
        oy = ring_y[ring_head];
        ring_head = (ring_head + 1) % WIN_DEPTH;
        ring_fill--;
        refresh_after_drop(ox, oy);
      end
    end
    s.min_x = lo_x;
    s.max_x = hi_x;
    s.min_y = lo_y;
    s.max_y = hi_y;
    s.fill  = LEN_BITS'(ring_fill);
    return s;
  endfunction

  // ----------------------------------------------------------------- drivers

  task automatic send_request(input logic kind,
                              input logic signed [SAMPLE_W-1:0] xs,
                              input logic signed [SAMPLE_W-1:0] ys);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_req.valid    <= 1'b1;
    in_req.req_type <= kind;
    in_req.x_sample <= xs;
    in_req.y_sample <= ys;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    pending_extremes[pend_wr % PEND_DEPTH] = apply_request(kind, xs, ys);
    pend_wr++;
    request_count++;
    if (kind == REQ_CLEAR) clear_count++;
  endtask

  // stop requesting and let every outstanding result come back
  task automatic drain_requests();
    in_req.valid <= 1'b0;
    burst_left = 0;
    while (pend_wr != pend_rd) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [LEN_BITS-1:0] len);
    cfg_wr.valid      <= 1'b1;
    cfg_wr.window_len <= len;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    cfg_wr.valid <= 1'b0;
    window_len_reg = len;
    len_writes++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int unsigned flavour);
    case (flavour)
      0: return $urandom_range(0, 6) - 3;    // narrow range, lots of ties
      1: return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX - $urandom_range(0, 3)
                                            : SAMPLE_MIN + $urandom_range(0, 3);
      2: begin
        // rising ramp: the oldest is the minimum until the ramp wraps past SAMPLE_MAX
        ramp_val = ramp_val + $urandom_range(1, 1000);
        return ramp_val;
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [LEN_BITS-1:0] pick_window_len();
    case ($urandom_range(0, 9))
      0: return 10'd513;
      1: return 10'd1023;
      2: return 10'd64;
      3: return 10'd0;
      default: return LEN_BITS'($urandom_range(1, 12));
    endcase
  endfunction

  // ------------------------------------------------------------- result side

  initial begin
    out_res.ready <= 1'b0;
    forever begin : receiver_pace
      int unsigned pace_count;
      int unsigned pace_mode;
      @(posedge clk);
      pace_count++;
      if (pace_count % 64 == 0) pace_mode = $urandom_range(0, 2);
      if (holding) begin
        out_res.ready <= 1'b0;
      end else begin
        case (pace_mode)
          0: out_res.ready <= 1'b1;
          1: out_res.ready <= 1'($urandom_range(0, 1));
          default: out_res.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always begin
    @(hold_off_ev);
    holding <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < 30) $display("mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [SAMPLE_W-1:0] got,
                             input logic [SAMPLE_W-1:0] wanted);
    if (got !== wanted)
      report_mismatch($sformatf("%s got %h, wanted %h (result %0d)",
                                name, got, wanted, checked_count));
  endtask

  always @(posedge clk) begin : result_check
    window_summary_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pend_wr == pend_rd) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_extremes[pend_rd % PEND_DEPTH];
        pend_rd++;
        check_field("min_x", out_res.min_x, want.min_x);
        check_field("max_x", out_res.max_x, want.max_x);
        check_field("min_y", out_res.min_y, want.min_y);
        check_field("max_y", out_res.max_y, want.max_y);
        check_field("fill_count", SAMPLE_W'(out_res.fill_count), SAMPLE_W'(want.fill));
        checked_count++;
      end
    end
  end

  // ------------------------------------------------------------------- tests

  task automatic test_directed_corners();
    send_request(REQ_CLEAR, SAMPLE_MAX, SAMPLE_MIN);
    send_request(REQ_ADD, SAMPLE_MAX, SAMPLE_MIN);
    send_request(REQ_ADD, SAMPLE_MIN, SAMPLE_MAX);
    send_request(REQ_ADD, '0, '0);
    send_request(REQ_ADD, -1, 1);
    send_request(REQ_ADD, 32'sh0001_0000, 32'shffff_0000);
    send_request(REQ_CLEAR, $urandom(), $urandom());
    send_request(REQ_ADD, 5, 5);
    drain_requests();
    // short window with ties on the extremes
    write_window_len(10'd2);
    send_request(REQ_ADD, 5, 9);
    send_request(REQ_ADD, 5, 7);
    send_request(REQ_ADD, 3, 7);
    send_request(REQ_ADD, 8, 7);
    drain_requests();
    // zero length behaves as one
    write_window_len(10'd0);
    send_request(REQ_ADD, -7, 100);
    send_request(REQ_ADD, 9, -100);
    drain_requests();
    write_window_len(10'd4);
    send_request(REQ_ADD, 10, -10);
    send_request(REQ_ADD, 11, -11);
    send_request(REQ_ADD, 12, -12);
    send_request(REQ_ADD, 13, -13);
    drain_requests();
    // lowered window: the next add drops several pairs at once
    write_window_len(10'd1);
    send_request(REQ_ADD, 0, 0);
    send_request(REQ_CLEAR, SAMPLE_MIN, SAMPLE_MAX);
    drain_requests();
  endtask

  task automatic test_full_ring_eviction();
    write_window_len(10'd1023);
    send_request(REQ_CLEAR, '0, '0);
    for (int n = 0; n < 530; n++) send_request(REQ_ADD, $urandom(), $urandom());
    drain_requests();
    write_window_len(10'd512);
    for (int n = 0; n < 4; n++) send_request(REQ_ADD, $urandom(), $urandom());
    drain_requests();
    write_window_len(10'd3);
    for (int n = 0; n < 5; n++) send_request(REQ_ADD, $urandom(), $urandom());
    drain_requests();
  endtask

  task automatic test_random_windows();
    int unsigned flavour;
    logic kind;
    for (int phase = 0; phase < 8; phase++) begin
      write_window_len(pick_window_len());
      flavour  = $urandom_range(0, 3);
      ramp_val = $urandom();
      if (phase == 2) -> hold_off_ev;
      for (int n = 0; n < 40; n++) begin
        kind = ($urandom_range(0, 15) == 0) ? REQ_CLEAR : REQ_ADD;
        if ($urandom_range(0, 7) == 0)
          send_request(kind, $urandom(), $urandom());
        else
          send_request(kind, pick_sample(flavour), pick_sample(flavour));
      end
      drain_requests();
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_req.valid      <= 1'b0;
    in_req.req_type   <= REQ_ADD;
    in_req.x_sample   <= '0;
    in_req.y_sample   <= '0;
    cfg_wr.valid      <= 1'b0;
    cfg_wr.window_len <= WINDOW_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_full_ring_eviction();
    test_random_windows();

    repeat (WIN_DEPTH + 16) @(posedge clk);
    $display("covered %0d requests (%0d clears), %0d window length writes incl. 0/512/1023",
             request_count, clear_count, len_writes);
    $display("%0d results checked, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timed out with %0d results outstanding", pend_wr - pend_rd);
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
hdl/swmm_pkg.sv
hdl/swmm_if.sv
hdl/swmm_ctrl.sv
hdl/swmm_dp.sv
hdl/sliding_window_minmax_tracker.sv
tb/tb_sliding_window_minmax_tracker.sv
